FILE: rtl/vp9pd_pkg.sv
// Shared types and constants for the VP9 payload descriptor parser.
package vp9pd_pkg;

  localparam int unsigned MaxRefsDefault = 3;
  localparam logic [3:0]  LayerLimitReset = 4'd5;
  localparam logic [15:0] ShortIdWrap = 16'd128;
  localparam logic [15:0] LongIdWrap = 16'd32768;
  localparam logic [15:0] ShortIdMax = 16'd127;
  localparam logic [15:0] LongIdMax = 16'd32767;
  localparam logic [15:0] OffsetMax = 16'hFFFF;

  typedef enum logic [3:0] {
    PH_FLAGS   = 4'd0,
    PH_PID1    = 4'd1,
    PH_PID2    = 4'd2,
    PH_LAYER   = 4'd3,
    PH_TL0     = 4'd4,
    PH_REF     = 4'd5,
    PH_SS      = 4'd6,
    PH_RES     = 4'd7,
    PH_NG      = 4'd8,
    PH_GOF     = 4'd9,
    PH_GOFDIFF = 4'd10,
    PH_PAYLOAD = 4'd11,
    PH_SKIP    = 4'd12
  } phase_e;

  typedef enum logic [3:0] {
    KIND_FLAGS    = 4'd0,
    KIND_PICID    = 4'd1,
    KIND_LAYER    = 4'd2,
    KIND_TL0      = 4'd3,
    KIND_REF      = 4'd4,
    KIND_SS       = 4'd5,
    KIND_RES      = 4'd6,
    KIND_GOFCOUNT = 4'd7,
    KIND_GOFENTRY = 4'd8,
    KIND_GOFDIFF  = 4'd9,
    KIND_PAYLOAD  = 4'd10,
    KIND_STATUS   = 4'd11
  } kind_e;

  typedef enum logic [2:0] {
    ERR_OK          = 3'd0,
    ERR_TRUNCATED   = 3'd1,
    ERR_SPATIAL_IDX = 3'd2,
    ERR_MANY_REFS   = 3'd3,
    ERR_REF_NO_PID  = 3'd4,
    ERR_MANY_LAYERS = 3'd5,
    ERR_NO_PAYLOAD  = 3'd6
  } err_e;

  typedef enum logic [2:0] {
    ENTER_PID   = 3'd1,
    ENTER_LAYER = 3'd2,
    ENTER_REF   = 3'd4,
    ENTER_SS    = 3'd5
  } enter_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] value;
    logic [15:0] aux_value;
    logic [7:0]  entry_index;
    logic [1:0]  sub_index;
    logic        flag_a;
    logic        flag_b;
    logic        packet_done;
    err_e        error_code;
    logic        first_in_frame;
  } rec_t;

endpackage

FILE: rtl/vp9pd_parse.sv
// Input register, descriptor parse state and per-beat record generation.
module vp9pd_parse #(
  parameter int unsigned MAX_REFS = vp9pd_pkg::MaxRefsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [3:0]       cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             in_end_i,
  input  logic             out_full_i,
  output logic             push_o,
  output vp9pd_pkg::rec_t  rec_o
);
  import vp9pd_pkg::*;

  localparam logic [2:0] MaxRefsW = 3'(MAX_REFS);

  logic       v1_q;
  logic [7:0] b_q;
  logic       end_q;
  logic       adv;
  logic [3:0] limit_q;

  phase_e      phase_q, phase_d, phase_n;
  logic [7:0]  flag_bits_q, flag_bits_d, flag_bits_n;
  logic [14:0] pid_q, pid_d;
  logic        pid_pres_q, pid_pres_d;
  logic        long_pid_q, long_pid_d;
  logic        inter_q, inter_d, inter_n;
  logic [1:0]  ref_count_q, ref_count_d;
  logic [3:0]  layer_total_q, layer_total_d;
  logic [2:0]  layer_cnt_q, layer_cnt_d;
  logic [7:0]  gof_total_q, gof_total_d;
  logic [7:0]  gof_cnt_q, gof_cnt_d;
  logic [1:0]  gof_refs_q, gof_refs_d;
  logic [1:0]  gof_rcnt_q, gof_rcnt_d;
  logic [7:0]  partial_q, partial_d;
  logic [1:0]  bif_q, bif_d;
  logic [15:0] offset_q, offset_d;
  err_e        err_q, err_d, err_n;
  logic [15:0] held_w_q, held_w_d;
  logic        gof_pres_q, gof_pres_d;
  logic [15:0] pstart_q, pstart_d, pstart_n;

  logic [2:0]  spatial;
  logic [3:0]  ns;
  logic        layer_bad;
  logic        ss_bad;
  logic [6:0]  pd;
  logic [15:0] ref_val;
  err_e        end_err;

  function automatic phase_e enter_phase(input logic [2:0] stage, input logic [7:0] f,
                                         input logic pres);
    phase_e ph;
    if (stage <= ENTER_PID && f[7]) begin
      ph = PH_PID1;
    end else if (stage <= ENTER_LAYER && f[5]) begin
      ph = PH_LAYER;
    end else if (stage <= ENTER_REF && f[6] && f[4]) begin
      ph = pres ? PH_REF : PH_SKIP;
    end else if (stage <= ENTER_SS && f[1]) begin
      ph = PH_SS;
    end else begin
      ph = PH_PAYLOAD;
    end
    return ph;
  endfunction

  assign adv        = v1_q && !out_full_i;
  assign in_ready_o = !v1_q || adv;

  assign spatial   = b_q[3:1];
  assign ns        = {1'b0, b_q[7:5]} + 4'd1;
  assign layer_bad = {1'b0, spatial} >= limit_q;
  assign ss_bad    = b_q[4] && (ns > limit_q);
  assign pd        = b_q[7:1];
  assign ref_val   = {1'b0, pid_q} + ((16'(pd) > {1'b0, pid_q}) ?
                     (long_pid_q ? LongIdWrap : ShortIdWrap) : 16'd0) - 16'(pd);

  // next state
  always_comb begin
    logic       do_enter;
    logic [2:0] stage;
    logic [2:0] n3;
    logic [3:0] n4;
    logic [8:0] n9;
    logic       next_gof;
    do_enter    = 1'b0;
    stage       = ENTER_PID;
    n3          = 3'd0;
    n4          = 4'd0;
    n9          = 9'd0;
    next_gof    = 1'b0;
    phase_n     = phase_q;
    flag_bits_n = flag_bits_q;
    pid_d       = pid_q;
    pid_pres_d  = pid_pres_q;
    long_pid_d  = long_pid_q;
    inter_n     = inter_q;
    ref_count_d = ref_count_q;
    layer_total_d = layer_total_q;
    layer_cnt_d = layer_cnt_q;
    gof_total_d = gof_total_q;
    gof_cnt_d   = gof_cnt_q;
    gof_refs_d  = gof_refs_q;
    gof_rcnt_d  = gof_rcnt_q;
    partial_d   = partial_q;
    bif_d       = bif_q;
    err_n       = err_q;
    held_w_d    = held_w_q;
    gof_pres_d  = gof_pres_q;

    unique case (phase_q)
      PH_FLAGS: begin
        flag_bits_n = b_q;
        do_enter    = 1'b1;
        stage       = ENTER_PID;
      end
      PH_PID1: begin
        if (b_q[7]) begin
          partial_d  = {1'b0, b_q[6:0]};
          long_pid_d = 1'b1;
          phase_n    = PH_PID2;
        end else begin
          pid_d      = {7'd0, b_q};
          pid_pres_d = 1'b1;
          long_pid_d = 1'b0;
          do_enter   = 1'b1;
          stage      = ENTER_LAYER;
        end
      end
      PH_PID2: begin
        pid_d      = {partial_q[6:0], b_q};
        pid_pres_d = 1'b1;
        do_enter   = 1'b1;
        stage      = ENTER_LAYER;
      end
      PH_LAYER: begin
        if (layer_bad) begin
          err_n   = ERR_SPATIAL_IDX;
          phase_n = PH_SKIP;
        end else begin
          inter_n = b_q[0];
          if (flag_bits_q[4]) begin
            do_enter = 1'b1;
            stage    = ENTER_REF;
          end else begin
            phase_n = PH_TL0;
          end
        end
      end
      PH_TL0: begin
        do_enter = 1'b1;
        stage    = ENTER_REF;
      end
      PH_REF: begin
        n3 = {1'b0, ref_count_q} + 3'd1;
        if (b_q[0]) begin
          if (n3 >= MaxRefsW) begin
            err_n   = ERR_MANY_REFS;
            phase_n = PH_SKIP;
          end else begin
            ref_count_d = n3[1:0];
          end
        end else begin
          ref_count_d = n3[1:0];
          do_enter    = 1'b1;
          stage       = ENTER_SS;
        end
      end
      PH_SS: begin
        if (ss_bad) begin
          err_n   = ERR_MANY_LAYERS;
          phase_n = PH_SKIP;
        end else begin
          layer_total_d = ns;
          layer_cnt_d   = 3'd0;
          bif_d         = 2'd0;
          gof_total_d   = 8'd0;
          gof_cnt_d     = 8'd0;
          gof_pres_d    = b_q[3];
          if (b_q[4]) begin
            phase_n = PH_RES;
          end else if (b_q[3]) begin
            phase_n = PH_NG;
          end else begin
            phase_n = PH_PAYLOAD;
          end
        end
      end
      PH_RES: begin
        if (bif_q == 2'd0 || bif_q == 2'd2) begin
          partial_d = b_q;
          bif_d     = bif_q + 2'd1;
        end else if (bif_q == 2'd1) begin
          held_w_d = {partial_q, b_q};
          bif_d    = 2'd2;
        end else begin
          bif_d = 2'd0;
          n4    = {1'b0, layer_cnt_q} + 4'd1;
          if (n4 >= layer_total_q) begin
            phase_n = gof_pres_q ? PH_NG : PH_PAYLOAD;
          end else begin
            layer_cnt_d = n4[2:0];
          end
        end
      end
      PH_NG: begin
        gof_total_d = b_q;
        gof_cnt_d   = 8'd0;
        phase_n     = (b_q == 8'd0) ? PH_PAYLOAD : PH_GOF;
      end
      PH_GOF: begin
        gof_refs_d = b_q[3:2];
        gof_rcnt_d = 2'd0;
        if (b_q[3:2] != 2'd0) begin
          phase_n = PH_GOFDIFF;
        end else begin
          next_gof = 1'b1;
        end
      end
      PH_GOFDIFF: begin
        n3 = {1'b0, gof_rcnt_q} + 3'd1;
        if (n3 >= {1'b0, gof_refs_q}) begin
          next_gof = 1'b1;
        end else begin
          gof_rcnt_d = n3[1:0];
        end
      end
      PH_PAYLOAD: begin
      end
      PH_SKIP: begin
      end
      default: begin
      end
    endcase

    if (next_gof) begin
      n9 = {1'b0, gof_cnt_q} + 9'd1;
      if (n9 >= {1'b0, gof_total_q}) begin
        phase_n = PH_PAYLOAD;
      end else begin
        gof_cnt_d = n9[7:0];
        phase_n   = PH_GOF;
      end
    end

    if (do_enter) begin
      phase_n = enter_phase(stage, flag_bits_n, pid_pres_d);
      if (phase_n == PH_SKIP) begin
        err_n = ERR_REF_NO_PID;
      end
      if (phase_n == PH_REF) begin
        ref_count_d = 2'd0;
      end
    end

    pstart_n = pstart_q;
    if (phase_n == PH_PAYLOAD && phase_q != PH_PAYLOAD) begin
      pstart_n = (offset_q < OffsetMax) ? offset_q + 16'd1 : OffsetMax;
    end

    phase_d     = phase_n;
    flag_bits_d = flag_bits_n;
    inter_d     = inter_n;
    err_d       = err_n;
    pstart_d    = pstart_n;
    offset_d    = (offset_q < OffsetMax) ? offset_q + 16'd1 : OffsetMax;

    if (end_q) begin
      phase_d       = PH_FLAGS;
      flag_bits_d   = 8'd0;
      pid_d         = 15'd0;
      pid_pres_d    = 1'b0;
      long_pid_d    = 1'b0;
      inter_d       = 1'b0;
      ref_count_d   = 2'd0;
      layer_total_d = 4'd0;
      layer_cnt_d   = 3'd0;
      gof_total_d   = 8'd0;
      gof_cnt_d     = 8'd0;
      gof_refs_d    = 2'd0;
      gof_rcnt_d    = 2'd0;
      partial_d     = 8'd0;
      bif_d         = 2'd0;
      offset_d      = 16'd0;
      err_d         = ERR_OK;
      held_w_d      = 16'd0;
      gof_pres_d    = 1'b0;
      pstart_d      = 16'd0;
    end
  end

  always_comb begin
    end_err = err_n;
    if (err_n == ERR_OK) begin
      if (phase_n != PH_PAYLOAD) begin
        end_err = ERR_TRUNCATED;
      end else if (phase_q != PH_PAYLOAD) begin
        end_err = ERR_NO_PAYLOAD;
      end
    end
  end

  // record outputs
  always_comb begin
    logic vld;
    vld   = 1'b0;
    rec_o = '0;
    unique case (phase_q)
      PH_FLAGS: begin
        vld        = 1'b1;
        rec_o.kind = KIND_FLAGS;
        rec_o.value = {8'd0, b_q};
      end
      PH_PID1: begin
        vld             = !b_q[7];
        rec_o.kind      = KIND_PICID;
        rec_o.value     = {8'd0, b_q};
        rec_o.aux_value = ShortIdMax;
      end
      PH_PID2: begin
        vld             = 1'b1;
        rec_o.kind      = KIND_PICID;
        rec_o.value     = {1'b0, partial_q[6:0], b_q};
        rec_o.aux_value = LongIdMax;
      end
      PH_LAYER: begin
        vld             = !layer_bad;
        rec_o.kind      = KIND_LAYER;
        rec_o.value     = {13'd0, b_q[7:5]};
        rec_o.aux_value = {13'd0, spatial};
        rec_o.flag_a    = b_q[4];
        rec_o.flag_b    = b_q[0];
      end
      PH_TL0: begin
        vld         = 1'b1;
        rec_o.kind  = KIND_TL0;
        rec_o.value = {8'd0, b_q};
      end
      PH_REF: begin
        vld               = 1'b1;
        rec_o.kind        = KIND_REF;
        rec_o.value       = ref_val;
        rec_o.aux_value   = {9'd0, pd};
        rec_o.entry_index = {6'd0, ref_count_q};
      end
      PH_SS: begin
        vld          = !ss_bad;
        rec_o.kind   = KIND_SS;
        rec_o.value  = {12'd0, ns};
        rec_o.flag_a = b_q[4];
        rec_o.flag_b = b_q[3];
      end
      PH_RES: begin
        vld               = (bif_q == 2'd3);
        rec_o.kind        = KIND_RES;
        rec_o.value       = held_w_q;
        rec_o.aux_value   = {partial_q, b_q};
        rec_o.entry_index = {5'd0, layer_cnt_q};
      end
      PH_NG: begin
        vld         = 1'b1;
        rec_o.kind  = KIND_GOFCOUNT;
        rec_o.value = {8'd0, b_q};
      end
      PH_GOF: begin
        vld               = 1'b1;
        rec_o.kind        = KIND_GOFENTRY;
        rec_o.value       = {13'd0, b_q[7:5]};
        rec_o.aux_value   = {14'd0, b_q[3:2]};
        rec_o.entry_index = gof_cnt_q;
        rec_o.flag_a      = b_q[4];
      end
      PH_GOFDIFF: begin
        vld               = 1'b1;
        rec_o.kind        = KIND_GOFDIFF;
        rec_o.value       = {8'd0, b_q};
        rec_o.entry_index = gof_cnt_q;
        rec_o.sub_index   = gof_rcnt_q;
      end
      PH_PAYLOAD: begin
        vld             = 1'b1;
        rec_o.kind      = KIND_PAYLOAD;
        rec_o.value     = {8'd0, b_q};
        rec_o.aux_value = offset_q;
      end
      PH_SKIP: begin
        vld = 1'b0;
      end
      default: begin
        vld = 1'b0;
      end
    endcase

    if (end_q) begin
      vld                  = 1'b1;
      rec_o                = '0;
      rec_o.kind           = KIND_STATUS;
      rec_o.value          = {8'd0, b_q};
      rec_o.aux_value      = (end_err == ERR_OK) ? pstart_n : 16'd0;
      rec_o.packet_done    = 1'b1;
      rec_o.error_code     = end_err;
      rec_o.first_in_frame = (end_err == ERR_OK) && flag_bits_n[3] &&
                             (!flag_bits_n[5] || !inter_n);
    end
    push_o = adv && vld;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LayerLimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (in_ready_o) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      b_q   <= in_byte_i;
      end_q <= in_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_FLAGS;
      flag_bits_q   <= 8'd0;
      pid_q         <= 15'd0;
      pid_pres_q    <= 1'b0;
      long_pid_q    <= 1'b0;
      inter_q       <= 1'b0;
      ref_count_q   <= 2'd0;
      layer_total_q <= 4'd0;
      layer_cnt_q   <= 3'd0;
      gof_total_q   <= 8'd0;
      gof_cnt_q     <= 8'd0;
      gof_refs_q    <= 2'd0;
      gof_rcnt_q    <= 2'd0;
      partial_q     <= 8'd0;
      bif_q         <= 2'd0;
      offset_q      <= 16'd0;
      err_q         <= ERR_OK;
      held_w_q      <= 16'd0;
      gof_pres_q    <= 1'b0;
      pstart_q      <= 16'd0;
    end else if (adv) begin
      phase_q       <= phase_d;
      flag_bits_q   <= flag_bits_d;
      pid_q         <= pid_d;
      pid_pres_q    <= pid_pres_d;
      long_pid_q    <= long_pid_d;
      inter_q       <= inter_d;
      ref_count_q   <= ref_count_d;
      layer_total_q <= layer_total_d;
      layer_cnt_q   <= layer_cnt_d;
      gof_total_q   <= gof_total_d;
      gof_cnt_q     <= gof_cnt_d;
      gof_refs_q    <= gof_refs_d;
      gof_rcnt_q    <= gof_rcnt_d;
      partial_q     <= partial_d;
      bif_q         <= bif_d;
      offset_q      <= offset_d;
      err_q         <= err_d;
      held_w_q      <= held_w_d;
      gof_pres_q    <= gof_pres_d;
      pstart_q      <= pstart_d;
    end
  end

`ifndef SYNTHESIS
  a_skip_has_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SKIP |-> err_q != ERR_OK)
    else $error("skip phase without a latched error");
  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && rec_o.packet_done |=> phase_q == PH_FLAGS && err_q == ERR_OK)
    else $error("state not cleared after packet end");
  a_err_no_fif: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && rec_o.error_code != ERR_OK |-> !rec_o.first_in_frame)
    else $error("first_in_frame set on failed packet");
  a_end_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && end_q |-> push_o && rec_o.kind == KIND_STATUS)
    else $error("packet end beat gave no status record");
`endif

endmodule

FILE: rtl/vp9pd_out_fifo.sv
// Two-entry result buffer between the parser and the output stream.
module vp9pd_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vp9pd_pkg::rec_t rec_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            ready_i,
  output vp9pd_pkg::rec_t rec_o
);
  import vp9pd_pkg::*;

  rec_t       mem_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2) && !ready_i;
  assign pop     = valid_o && ready_i;
  assign rec_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q != 2'd2 || pop)
    else $error("push into full result buffer");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer count out of range");
`endif

endmodule

FILE: rtl/vp9_payload_descriptor_parser.sv
// VP9 RTP payload descriptor parser, top level.
// One payload byte is taken per beat, and a new beat can be taken every cycle; each byte
// gives at most one tagged record: the byte is held in the input register, then the parse
// logic writes its record into the two-entry result buffer. The input side stalls
// only when that buffer is full and the output side is held off. The byte marked tlast
// ends the packet and gives a status record (tlast high on the output) with the error
// code, the payload start offset and the first-in-frame flag. spatial_layer_limit is
// written through cfg_we_i/cfg_wdata_i, resets to 5, and must only change while idle.
module vp9_payload_descriptor_parser #(
  parameter int unsigned MAX_REFS = vp9pd_pkg::MaxRefsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] value, [31:16] aux_value, [39:32] entry_index, [41:40] sub_index,
  // [42] flag_a, [43] flag_b, [46:44] error_code, [47] first_in_frame
  output logic [47:0] m_axis_tdata_o,
  output logic [3:0]  m_axis_tuser_o,   // [3:0] record_kind
  output logic        m_axis_tlast_o
);
  import vp9pd_pkg::*;

  logic push;
  logic full;
  rec_t rec_in;
  rec_t rec_out;

  vp9pd_parse #(
    .MAX_REFS(MAX_REFS)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_end_i   (s_axis_tlast_i),
    .out_full_i (full),
    .push_o     (push),
    .rec_o      (rec_in)
  );

  vp9pd_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (rec_in),
    .full_o (full),
    .valid_o(m_axis_tvalid_o),
    .ready_i(m_axis_tready_i),
    .rec_o  (rec_out)
  );

  assign m_axis_tdata_o = {rec_out.first_in_frame, rec_out.error_code, rec_out.flag_b,
                           rec_out.flag_a, rec_out.sub_index, rec_out.entry_index,
                           rec_out.aux_value, rec_out.value};
  assign m_axis_tuser_o = rec_out.kind;
  assign m_axis_tlast_o = rec_out.packet_done;

endmodule
